// ----- sv/gacrc_pkg.sv -----
// Shared types and constants for the GPS-A checksummed line parser.
// No dependencies; used by gacrc_parser and gps_a_crc_line_parser_top.
package gacrc_pkg;

  localparam logic [6:0] MaxLineBytes = 7'd100;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHigh   = 8'h80;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_DOLLAR  = 4'd1,
    PH_C1      = 4'd2,
    PH_R       = 4'd3,
    PH_C2      = 4'd4,
    PH_SUM0    = 4'd5,
    PH_SUM1    = 4'd6,
    PH_SUM2    = 4'd7,
    PH_SUM3    = 4'd8,
    PH_COMMA   = 4'd9,
    PH_LINE    = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [6:0] len;
  } result_t;

endpackage

// ----- sv/gacrc_parser.sv -----
// Header hunt, checksum capture, line CRC and end-of-line compare.
// Depends on gacrc_pkg. Holds the parse state; the result is combinational.
module gacrc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  output gacrc_pkg::result_t res_o
);

  gacrc_pkg::phase_e phase_q, phase_d;
  logic [15:0]       crc_q, crc_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [7:0]        exp_q [4];
  logic              exp_we;
  logic [1:0]        exp_idx;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ gacrc_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  logic        above_space, printable, match;
  logic [15:0] crc_upd, sum;

  assign above_space = (byte_i > gacrc_pkg::ChSpace) && (byte_i < gacrc_pkg::ChHigh);
  assign printable   = (byte_i >= gacrc_pkg::ChSpace) && (byte_i < gacrc_pkg::ChHigh);
  assign crc_upd     = crc_byte(crc_q, byte_i);
  assign sum         = ~crc_upd;
  assign match       = (exp_q[0] == hex_char(sum[15:12])) && (exp_q[1] == hex_char(sum[11:8]))
                    && (exp_q[2] == hex_char(sum[7:4]))   && (exp_q[3] == hex_char(sum[3:0]));
  assign exp_idx     = 2'(phase_q - gacrc_pkg::PH_SUM0);

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    exp_we  = 1'b0;
    res_o   = '{valid: 1'b0, kind: gacrc_pkg::KIND_PAYLOAD, data: 8'h00, len: 7'd0};
    unique case (phase_q)
      gacrc_pkg::PH_DOLLAR:
        phase_d = (byte_i == gacrc_pkg::ChDollar) ? gacrc_pkg::PH_C1 : gacrc_pkg::PH_HUNT;
      gacrc_pkg::PH_C1:
        phase_d = (byte_i == gacrc_pkg::ChC) ? gacrc_pkg::PH_R : gacrc_pkg::PH_HUNT;
      gacrc_pkg::PH_R:
        phase_d = (byte_i == gacrc_pkg::ChR) ? gacrc_pkg::PH_C2 : gacrc_pkg::PH_HUNT;
      gacrc_pkg::PH_C2:
        phase_d = (byte_i == gacrc_pkg::ChC) ? gacrc_pkg::PH_SUM0 : gacrc_pkg::PH_HUNT;
      gacrc_pkg::PH_SUM0, gacrc_pkg::PH_SUM1, gacrc_pkg::PH_SUM2, gacrc_pkg::PH_SUM3: begin
        if (above_space) begin
          exp_we  = 1'b1;
          phase_d = gacrc_pkg::phase_e'(phase_q + 4'd1);
        end else begin
          phase_d = gacrc_pkg::PH_HUNT;
        end
      end
      gacrc_pkg::PH_COMMA: begin
        if (byte_i == gacrc_pkg::ChComma) begin
          phase_d = gacrc_pkg::PH_LINE;
          cnt_d   = 7'd0;
          crc_d   = gacrc_pkg::CrcInit;
        end else begin
          phase_d = gacrc_pkg::PH_HUNT;
        end
      end
      gacrc_pkg::PH_LINE: begin
        res_o.valid = 1'b1;
        if (cnt_q >= gacrc_pkg::MaxLineBytes) begin
          phase_d    = gacrc_pkg::PH_HUNT;
          res_o.kind = gacrc_pkg::KIND_TOO_LONG;
        end else begin
          crc_d = crc_upd;
          if (printable) begin
            cnt_d      = cnt_q + 7'd1;
            res_o.data = byte_i;
          end else begin
            // terminator: CRC already includes it
            phase_d    = gacrc_pkg::PH_HUNT;
            res_o.kind = match ? gacrc_pkg::KIND_ACCEPT : gacrc_pkg::KIND_MISMATCH;
            res_o.len  = cnt_q;
          end
        end
      end
      default:
        phase_d = (byte_i == gacrc_pkg::ChDollar) ? gacrc_pkg::PH_DOLLAR : gacrc_pkg::PH_HUNT;
    endcase
    if (!fire_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gacrc_pkg::PH_HUNT;
      crc_q   <= gacrc_pkg::CrcInit;
      cnt_q   <= 7'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && exp_we) begin
      exp_q[exp_idx] <= byte_i;
    end
  end

endmodule

// ----- sv/gps_a_crc_line_parser_top.sv -----
// GPS-A checksummed line parser, top level.
// Depends on gacrc_pkg and gacrc_parser.
//
// Input channel: in_valid_i / in_stall_o / in_byte_i carries slow-data bytes.
// Output channel: out_valid_o / out_stall_i carries result words
// (out_kind_o, out_byte_o, line_length_o). A word moves at a rising edge with
// valid high and stall low.
// The block hunts for "$$CRC", stores four checksum characters, expects a
// comma and then forwards each printable payload byte as a kind-0 word. A
// byte below space or from 0x80 up ends the line and gives one accept or
// mismatch word with the payload length; a line of 100 bytes or more gives one
// drop word. Header bytes give no word.
// A byte taken into the input register goes through the parser into the result register.
// Throughput: one byte per cycle while out_stall_i holds no word, set by the combinational
// CRC/state step between the input register and the result register.
// Reset clears the parse state, the CRC and both stage valids.
// When out_stall_i holds a word, the input register holds its byte and
// in_stall_o rises once that register is full; nothing is dropped.
module gps_a_crc_line_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [6:0] line_length_o
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  logic [1:0]         out_kind_q;
  logic [7:0]         out_byte_q;
  logic [6:0]         out_len_q;
  logic               can_out, advance;
  gacrc_pkg::result_t res;

  assign can_out    = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && can_out;
  assign in_stall_o = in_valid_q && !can_out;

  gacrc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (can_out) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
    if (can_out && res.valid) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.data;
      out_len_q  <= res.len;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign line_length_o = out_len_q;

endmodule
